>>> rtl/arm_hover_land_mission_sequencer_assert.svh
// Assertion macros for the sequencer RTL, used by the plan queue.
`ifndef ARM_HOVER_LAND_MISSION_SEQUENCER_ASSERT_SVH
`define ARM_HOVER_LAND_MISSION_SEQUENCER_ASSERT_SVH

`ifndef SYNTHESIS
`define AHL_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define AHL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AHL_ASSERT(lbl, clk, rst_n, prop, msg)
`define AHL_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> rtl/ahl_pkg.sv
// Types, codes and helpers shared by the mission sequencer modules.
package ahl_pkg;

  typedef enum logic [4:0] {
    PH_PRESTREAM  = 5'b00001,
    PH_WAIT_ARMED = 5'b00010,
    PH_FLYING     = 5'b00100,
    PH_LANDING    = 5'b01000,
    PH_DONE       = 5'b10000
  } phase_t;

  localparam logic [2:0] PHC_PRESTREAM  = 3'd0;
  localparam logic [2:0] PHC_WAIT_ARMED = 3'd1;
  localparam logic [2:0] PHC_FLYING     = 3'd2;
  localparam logic [2:0] PHC_LANDING    = 3'd3;
  localparam logic [2:0] PHC_DONE       = 3'd4;

  localparam logic [2:0] MSG_SETPOINT = 3'd0;
  localparam logic [2:0] MSG_MODE     = 3'd1;
  localparam logic [2:0] MSG_ARM      = 3'd2;
  localparam logic [2:0] MSG_LAND     = 3'd3;
  localparam logic [2:0] MSG_NOTICE   = 3'd4;

  localparam logic [2:0] REG_HOVER_TICKS   = 3'd0;
  localparam logic [2:0] REG_TAKEOFF_HT    = 3'd1;
  localparam logic [2:0] REG_MISSION_LIMIT = 3'd2;
  localparam logic [2:0] REG_ARM_LIMIT     = 3'd3;
  localparam logic [2:0] REG_PRESTREAM     = 3'd4;
  localparam logic [2:0] REG_ARM_RETRY     = 3'd5;
  localparam logic [2:0] REG_LAND_RETRY    = 3'd6;

  localparam logic [13:0] HEIGHT_MAX = 14'd10000;

  typedef struct packed {
    logic [15:0] hover_ticks;
    logic [13:0] takeoff_height_cm;
    logic [15:0] mission_limit_ticks;
    logic [15:0] arm_limit_ticks;
    logic [7:0]  prestream_count;
    logic [7:0]  arm_retry_ticks;
    logic [7:0]  land_retry_ticks;
  } cfg_t;

  // Messages one tick calls for, handed from front to back.
  typedef struct packed {
    logic [1:0]  msg_cnt;
    logic [2:0]  kind0;
    logic [2:0]  kind1;
    logic [2:0]  kind2;
    logic [13:0] height;
    logic [2:0]  phase;
    logic        finished;
  } plan_t;

  function automatic logic [2:0] phase_code(phase_t p);
    logic [2:0] c;
    unique case (p)
      PH_PRESTREAM:  c = PHC_PRESTREAM;
      PH_WAIT_ARMED: c = PHC_WAIT_ARMED;
      PH_FLYING:     c = PHC_FLYING;
      PH_LANDING:    c = PHC_LANDING;
      PH_DONE:       c = PHC_DONE;
      default:       c = PHC_DONE;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/ahl_cfg_regs.sv
// APB register file holding the mission configuration.
module ahl_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output ahl_pkg::cfg_t cfg
);

  ahl_pkg::cfg_t cfg_r;
  logic          wr_en;
  logic [2:0]    reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hover_ticks         <= 16'd100;
      cfg_r.takeoff_height_cm   <= 14'd300;
      cfg_r.mission_limit_ticks <= 16'd450;
      cfg_r.arm_limit_ticks     <= 16'd120;
      cfg_r.prestream_count     <= 8'd20;
      cfg_r.arm_retry_ticks     <= 8'd10;
      cfg_r.land_retry_ticks    <= 8'd20;
    end else if (wr_en) begin
      unique case (reg_idx)
        ahl_pkg::REG_HOVER_TICKS:   cfg_r.hover_ticks         <= pwdata[15:0];
        ahl_pkg::REG_TAKEOFF_HT:    cfg_r.takeoff_height_cm   <= pwdata[13:0];
        ahl_pkg::REG_MISSION_LIMIT: cfg_r.mission_limit_ticks <= pwdata[15:0];
        ahl_pkg::REG_ARM_LIMIT:     cfg_r.arm_limit_ticks     <= pwdata[15:0];
        ahl_pkg::REG_PRESTREAM:     cfg_r.prestream_count     <= pwdata[7:0];
        ahl_pkg::REG_ARM_RETRY:     cfg_r.arm_retry_ticks     <= pwdata[7:0];
        ahl_pkg::REG_LAND_RETRY:    cfg_r.land_retry_ticks    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      ahl_pkg::REG_HOVER_TICKS:   prdata = 32'(cfg_r.hover_ticks);
      ahl_pkg::REG_TAKEOFF_HT:    prdata = 32'(cfg_r.takeoff_height_cm);
      ahl_pkg::REG_MISSION_LIMIT: prdata = 32'(cfg_r.mission_limit_ticks);
      ahl_pkg::REG_ARM_LIMIT:     prdata = 32'(cfg_r.arm_limit_ticks);
      ahl_pkg::REG_PRESTREAM:     prdata = 32'(cfg_r.prestream_count);
      ahl_pkg::REG_ARM_RETRY:     prdata = 32'(cfg_r.arm_retry_ticks);
      ahl_pkg::REG_LAND_RETRY:    prdata = 32'(cfg_r.land_retry_ticks);
      default:                    prdata = 32'd0;
    endcase
  end

endmodule

>>> rtl/ahl_front.sv
// Front end: takes ticks, advances phase and counters, plans the messages.
module ahl_front #(
  parameter int COUNTER_BITS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           accept,
  input  logic           vehicle_armed,
  input  logic           offboard_active,
  input  ahl_pkg::cfg_t  cfg,
  output logic           push,
  output ahl_pkg::plan_t plan
);

  ahl_pkg::phase_t         phase_r, phase_nxt;
  logic [COUNTER_BITS-1:0] mt_r, mt_nxt, b_mt;
  logic [COUNTER_BITS-1:0] pt_r, pt_nxt, b_pt;
  logic [COUNTER_BITS-1:0] tc_r, tc_nxt, b_tc;
  logic [7:0]              ss_r, ss_nxt, b_ss;
  logic [13:0]             height;
  logic                    retry;
  logic                    active;

  assign b_mt   = (&mt_r) ? mt_r : mt_r + 1'b1;
  assign b_pt   = (&pt_r) ? pt_r : pt_r + 1'b1;
  assign b_tc   = (&tc_r) ? tc_r : tc_r + 1'b1;
  assign b_ss   = (&ss_r) ? ss_r : ss_r + 1'b1;
  assign height = (cfg.takeoff_height_cm > ahl_pkg::HEIGHT_MAX) ?
                  ahl_pkg::HEIGHT_MAX : cfg.takeoff_height_cm;
  assign active = accept && (phase_r != ahl_pkg::PH_DONE);

  always_comb begin
    phase_nxt = phase_r;
    mt_nxt    = mt_r;
    pt_nxt    = pt_r;
    tc_nxt    = tc_r;
    ss_nxt    = ss_r;
    retry     = 1'b0;
    plan      = '0;
    if (active) begin
      mt_nxt = b_mt;
      pt_nxt = b_pt;
      tc_nxt = b_tc;
      priority if (phase_r != ahl_pkg::PH_LANDING &&
                   32'(b_mt) > 32'(cfg.mission_limit_ticks)) begin
        // safety timeout
        plan.msg_cnt = 2'd1;
        plan.kind0   = ahl_pkg::MSG_LAND;
        phase_nxt    = ahl_pkg::PH_LANDING;
        pt_nxt       = '0;
      end else if (phase_r == ahl_pkg::PH_PRESTREAM) begin
        ss_nxt       = b_ss;
        plan.msg_cnt = 2'd1;
        plan.kind0   = ahl_pkg::MSG_SETPOINT;
        if (b_ss >= cfg.prestream_count) begin
          plan.msg_cnt = 2'd3;
          plan.kind1   = ahl_pkg::MSG_MODE;
          plan.kind2   = ahl_pkg::MSG_ARM;
          tc_nxt       = '0;
          phase_nxt    = ahl_pkg::PH_WAIT_ARMED;
          pt_nxt       = '0;
        end
      end else if (phase_r == ahl_pkg::PH_WAIT_ARMED) begin
        plan.msg_cnt = 2'd1;
        plan.kind0   = ahl_pkg::MSG_SETPOINT;
        if (vehicle_armed && offboard_active) begin
          phase_nxt = ahl_pkg::PH_FLYING;
          pt_nxt    = '0;
        end else begin
          if (32'(b_tc) > 32'(cfg.arm_retry_ticks)) begin
            retry  = 1'b1;
            tc_nxt = '0;
          end
          // arm timeout wins over a retry pair
          if (32'(b_pt) > 32'(cfg.arm_limit_ticks)) begin
            plan.msg_cnt = 2'd2;
            plan.kind1   = ahl_pkg::MSG_LAND;
            phase_nxt    = ahl_pkg::PH_LANDING;
            pt_nxt       = '0;
          end else if (retry) begin
            plan.msg_cnt = 2'd3;
            plan.kind1   = ahl_pkg::MSG_MODE;
            plan.kind2   = ahl_pkg::MSG_ARM;
          end
        end
      end else if (phase_r == ahl_pkg::PH_FLYING) begin
        plan.msg_cnt = 2'd1;
        plan.kind0   = ahl_pkg::MSG_SETPOINT;
        if (32'(b_pt) >= 32'(cfg.hover_ticks)) begin
          plan.msg_cnt = 2'd2;
          plan.kind1   = ahl_pkg::MSG_LAND;
          tc_nxt       = '0;
          phase_nxt    = ahl_pkg::PH_LANDING;
          pt_nxt       = '0;
        end
      end else begin
        if (!vehicle_armed) begin
          plan.msg_cnt  = 2'd1;
          plan.kind0    = ahl_pkg::MSG_NOTICE;
          plan.finished = 1'b1;
          phase_nxt     = ahl_pkg::PH_DONE;
          pt_nxt        = '0;
        end else if (32'(b_tc) > 32'(cfg.land_retry_ticks)) begin
          plan.msg_cnt = 2'd1;
          plan.kind0   = ahl_pkg::MSG_LAND;
          tc_nxt       = '0;
        end
      end
    end
    plan.height = height;
    plan.phase  = ahl_pkg::phase_code(phase_nxt);
  end

  assign push = active && (plan.msg_cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ahl_pkg::PH_PRESTREAM;
      mt_r    <= '0;
      pt_r    <= '0;
      tc_r    <= '0;
      ss_r    <= '0;
    end else begin
      phase_r <= phase_nxt;
      mt_r    <= mt_nxt;
      pt_r    <= pt_nxt;
      tc_r    <= tc_nxt;
      ss_r    <= ss_nxt;
    end
  end

endmodule

>>> rtl/ahl_queue.sv
// Two-entry plan queue between front and back end.
`include "arm_hover_land_mission_sequencer_assert.svh"

module ahl_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ahl_pkg::plan_t wdata,
  input  logic           pop,
  output ahl_pkg::plan_t rdata,
  output logic           full,
  output logic           empty
);

  localparam int DEPTH = 2;

  ahl_pkg::plan_t mem_r [DEPTH];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     count_r, count_nxt;

  assign full  = (count_r == 2'(DEPTH));
  assign empty = (count_r == 2'd0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `AHL_ASSERT(a_count_bound, clk, rst_n, count_r <= 2'(DEPTH), "plan queue count over depth")
  `AHL_ASSERT(a_no_overflow, clk, rst_n, full |-> !push, "plan pushed into full queue")
  `AHL_ASSERT(a_no_underflow, clk, rst_n, empty |-> !pop, "plan popped from empty queue")

endmodule

>>> rtl/ahl_back.sv
// Back end: walks each queued plan and drives one result per cycle while out_stall is low.
module ahl_back (
  input  logic           clk,
  input  logic           rst_n,
  input  ahl_pkg::plan_t head,
  input  logic           empty,
  output logic           pop,
  input  logic           out_stall,
  output logic           out_valid,
  output logic [2:0]     out_message_kind,
  output logic [13:0]    out_setpoint_height_cm,
  output logic [2:0]     out_phase,
  output logic           out_mission_finished,
  output logic           out_last_of_tick
);

  logic [1:0]  idx_r, idx_nxt;
  logic        valid_r, valid_nxt;
  logic [2:0]  kind_r, kind_sel;
  logic [13:0] height_r;
  logic [2:0]  phase_r;
  logic        fin_r, last_r, last_sel;
  logic        load, take;

  assign load     = !valid_r || !out_stall;
  assign take     = load && !empty;
  assign last_sel = (idx_r == (head.msg_cnt - 2'd1));
  assign pop      = take && last_sel;

  always_comb begin
    unique case (idx_r)
      2'd0:    kind_sel = head.kind0;
      2'd1:    kind_sel = head.kind1;
      2'd2:    kind_sel = head.kind2;
      default: kind_sel = head.kind2;
    endcase
  end

  always_comb begin
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    if (load) begin
      valid_nxt = !empty;
    end
    if (take) begin
      idx_nxt = last_sel ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      kind_r   <= kind_sel;
      height_r <= (kind_sel == ahl_pkg::MSG_SETPOINT) ? head.height : 14'd0;
      phase_r  <= head.phase;
      fin_r    <= head.finished;
      last_r   <= last_sel;
    end
  end

  assign out_valid              = valid_r;
  assign out_message_kind       = kind_r;
  assign out_setpoint_height_cm = height_r;
  assign out_phase              = phase_r;
  assign out_mission_finished   = fin_r;
  assign out_last_of_tick       = last_r;

endmodule

>>> rtl/arm_hover_land_mission_sequencer.sv
// Top level of the arm, hover and land mission sequencer.
// One tick transaction is taken per cycle while the two-entry plan queue has
// room; the front end updates phase and counters for that tick as it is taken.
// The back end then delivers the tick's results (one to three) one per cycle
// from its output register while out_stall is low, and that output stage sets
// the sustained rate, most of all for a tick that emits setpoint, mode and arm.
// Ticks with no result, and all ticks once the mission is done, put nothing in
// the queue. Configuration registers sit on the APB port at byte offsets 0x00
// through 0x18 and should be written while idle.
module arm_hover_land_mission_sequencer #(
  parameter int COUNTER_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_vehicle_armed,
  input  logic        in_offboard_active,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_message_kind,
  output logic [13:0] out_setpoint_height_cm,
  output logic [2:0]  out_phase,
  output logic        out_mission_finished,
  output logic        out_last_of_tick,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  ahl_pkg::cfg_t  cfg;
  ahl_pkg::plan_t plan, head;
  logic           push, pop, full, empty, accept;

  assign in_stall = full;
  assign accept   = in_valid && !in_stall;

  ahl_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  ahl_front #(
    .COUNTER_BITS(COUNTER_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .vehicle_armed  (in_vehicle_armed),
    .offboard_active(in_offboard_active),
    .cfg            (cfg),
    .push           (push),
    .plan           (plan)
  );

  ahl_queue u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (push),
    .wdata(plan),
    .pop  (pop),
    .rdata(head),
    .full (full),
    .empty(empty)
  );

  ahl_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .head                  (head),
    .empty                 (empty),
    .pop                   (pop),
    .out_stall             (out_stall),
    .out_valid             (out_valid),
    .out_message_kind      (out_message_kind),
    .out_setpoint_height_cm(out_setpoint_height_cm),
    .out_phase             (out_phase),
    .out_mission_finished  (out_mission_finished),
    .out_last_of_tick      (out_last_of_tick)
  );

endmodule

>>> test/tb_arm_hover_land_mission_sequencer.sv
// Self-checking testbench for the arm, hover and land mission sequencer.
`timescale 1ns / 100ps

module tb_arm_hover_land_mission_sequencer;

  localparam int unsigned CNT_MAX      = (1 << 16) - 1;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned LIMIT_CYCLES = 300000;

  typedef struct packed {
    logic armed;
    logic offboard;
  } tick_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [13:0] height;
    logic [2:0]  phase;
    logic        finished;
    logic        last;
  } mission_msg_t;

  typedef enum {MIX_ANY, MIX_NOT_BOTH, MIX_ARMED} flag_mix_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_vehicle_armed;
  logic        in_offboard_active;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_message_kind;
  logic [13:0] out_setpoint_height_cm;
  logic [2:0]  out_phase;
  logic        out_mission_finished;
  logic        out_last_of_tick;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  arm_hover_land_mission_sequencer u_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_vehicle_armed       (in_vehicle_armed),
    .in_offboard_active     (in_offboard_active),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_message_kind       (out_message_kind),
    .out_setpoint_height_cm (out_setpoint_height_cm),
    .out_phase              (out_phase),
    .out_mission_finished   (out_mission_finished),
    .out_last_of_tick       (out_last_of_tick),
    .psel                   (psel),
    .penable                (penable),
    .pwrite                 (pwrite),
    .paddr                  (paddr),
    .pwdata                 (pwdata),
    .prdata                 (prdata),
    .pready                 (pready)
  );

  // mission predictor state
  ahl_pkg::cfg_t mcfg;
  logic [2:0]   cur_phase;
  int unsigned  mission_age;
  int unsigned  phase_age;
  int unsigned  command_age;
  int unsigned  streamed_cnt;

  tick_t        tick_queue[$];
  mission_msg_t due_msgs[$];
  tick_t        next_tick;
  logic         tick_taken;
  int unsigned  send_gap;
  int unsigned  send_steady;
  int unsigned  stall_left;
  int unsigned  free_left;
  int unsigned  ticks_sent;
  int unsigned  cycle_cnt;
  int unsigned  errors;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int unsigned bump(int unsigned c);
    return (c < CNT_MAX) ? c + 1 : c;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic enter_phase(input logic [2:0] next_phase);
    cur_phase = next_phase;
    phase_age = 0;
  endtask

  // Works out the messages one tick transaction causes and queues them.
  task automatic step_mission(input logic armed, input logic offboard);
    logic [2:0]   kinds [3];
    int           n;
    int           k;
    logic         fin;
    logic         retry;
    logic [13:0]  h;
    mission_msg_t m;
    if (cur_phase == ahl_pkg::PHC_DONE) return;
    n = 0;
    fin = 1'b0;
    retry = 1'b0;
    h = (mcfg.takeoff_height_cm > ahl_pkg::HEIGHT_MAX) ?
        ahl_pkg::HEIGHT_MAX : mcfg.takeoff_height_cm;
    mission_age = bump(mission_age);
    phase_age = bump(phase_age);
    command_age = bump(command_age);
    if (cur_phase != ahl_pkg::PHC_LANDING && mission_age > mcfg.mission_limit_ticks) begin
      kinds[n] = ahl_pkg::MSG_LAND; n++;
      enter_phase(ahl_pkg::PHC_LANDING);
    end else if (cur_phase == ahl_pkg::PHC_PRESTREAM) begin
      kinds[n] = ahl_pkg::MSG_SETPOINT; n++;
      if (streamed_cnt < 255) streamed_cnt++;
      if (streamed_cnt >= mcfg.prestream_count) begin
        kinds[n] = ahl_pkg::MSG_MODE; n++;
        kinds[n] = ahl_pkg::MSG_ARM; n++;
        command_age = 0;
        enter_phase(ahl_pkg::PHC_WAIT_ARMED);
      end
    end else if (cur_phase == ahl_pkg::PHC_WAIT_ARMED) begin
      kinds[n] = ahl_pkg::MSG_SETPOINT; n++;
      if (armed && offboard) begin
        enter_phase(ahl_pkg::PHC_FLYING);
      end else if (command_age > mcfg.arm_retry_ticks) begin
        retry = 1'b1;
        command_age = 0;
      end
      // arm timeout wins over the retry pair; the retry still clears the age
      if (cur_phase == ahl_pkg::PHC_WAIT_ARMED && phase_age > mcfg.arm_limit_ticks) begin
        kinds[n] = ahl_pkg::MSG_LAND; n++;
        enter_phase(ahl_pkg::PHC_LANDING);
      end else if (retry) begin
        kinds[n] = ahl_pkg::MSG_MODE; n++;
        kinds[n] = ahl_pkg::MSG_ARM; n++;
      end
    end else if (cur_phase == ahl_pkg::PHC_FLYING) begin
      kinds[n] = ahl_pkg::MSG_SETPOINT; n++;
      if (phase_age >= mcfg.hover_ticks) begin
        kinds[n] = ahl_pkg::MSG_LAND; n++;
        command_age = 0;
        enter_phase(ahl_pkg::PHC_LANDING);
      end
    end else begin
      if (!armed) begin
        kinds[n] = ahl_pkg::MSG_NOTICE; n++;
        fin = 1'b1;
        enter_phase(ahl_pkg::PHC_DONE);
      end else if (command_age > mcfg.land_retry_ticks) begin
        kinds[n] = ahl_pkg::MSG_LAND; n++;
        command_age = 0;
      end
    end
    for (k = 0; k < n; k++) begin
      m.kind = kinds[k];
      m.height = (kinds[k] == ahl_pkg::MSG_SETPOINT) ? h : 14'd0;
      m.phase = cur_phase;
      m.finished = fin;
      m.last = (k == n - 1);
      due_msgs.push_back(m);
    end
  endtask

  // input side: acceptance and prediction at the rising edge
  always @(posedge clk) begin
    tick_taken = rst_n && in_valid && !in_stall;
    if (tick_taken) step_mission(in_vehicle_armed, in_offboard_active);
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || tick_taken) begin
      if (send_gap != 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (tick_queue.size() != 0) begin
        next_tick = tick_queue.pop_front();
        in_valid <= 1'b1;
        in_vehicle_armed <= next_tick.armed;
        in_offboard_active <= next_tick.offboard;
        if (send_steady != 0) begin
          send_steady--;
        end else if ($urandom_range(0, 19) == 0) begin
          send_steady = $urandom_range(15, 40);
        end else begin
          send_gap = pick_gap();
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (free_left != 0) begin
      free_left--;
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 19) == 0) begin
      free_left = $urandom_range(20, 50);
      out_stall <= 1'b0;
    end else begin
      stall_left = pick_gap();
      if (stall_left != 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : result_check
    mission_msg_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (due_msgs.size() == 0) begin
        $error("result transaction with nothing expected: kind %0d phase %0d",
               out_message_kind, out_phase);
        errors++;
      end else begin
        want = due_msgs.pop_front();
        check_field("message_kind", want.kind, out_message_kind);
        check_field("setpoint_height_cm", want.height, out_setpoint_height_cm);
        check_field("phase", want.phase, out_phase);
        check_field("mission_finished", want.finished, out_mission_finished);
        check_field("last_of_tick", want.last, out_last_of_tick);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("tb_arm_hover_land_mission_sequencer: errors");
      $finish;
    end
  end

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      ahl_pkg::REG_HOVER_TICKS:   mcfg.hover_ticks = val[15:0];
      ahl_pkg::REG_TAKEOFF_HT:    mcfg.takeoff_height_cm = val[13:0];
      ahl_pkg::REG_MISSION_LIMIT: mcfg.mission_limit_ticks = val[15:0];
      ahl_pkg::REG_ARM_LIMIT:     mcfg.arm_limit_ticks = val[15:0];
      ahl_pkg::REG_PRESTREAM:     mcfg.prestream_count = val[7:0];
      ahl_pkg::REG_ARM_RETRY:     mcfg.arm_retry_ticks = val[7:0];
      ahl_pkg::REG_LAND_RETRY:    mcfg.land_retry_ticks = val[7:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic push_tick(input logic armed, input logic offboard);
    tick_t t;
    t.armed = armed;
    t.offboard = offboard;
    tick_queue.push_back(t);
    ticks_sent++;
  endtask

  task automatic queue_ticks(input int unsigned count, input flag_mix_t mix);
    int unsigned i;
    logic        a;
    logic        o;
    for (i = 0; i < count; i++) begin
      a = 1'($urandom_range(0, 1));
      o = 1'($urandom_range(0, 1));
      if (mix == MIX_NOT_BOTH && a && o) begin
        if ($urandom_range(0, 1)) a = 1'b0;
        else o = 1'b0;
      end
      if (mix == MIX_ARMED) a = 1'b1;
      push_tick(a, o);
    end
  endtask

  // block is idle: all ticks taken, all results seen, no-result ticks drained
  task automatic wait_quiet();
    @(posedge clk);
    while (tick_queue.size() != 0 || in_valid || due_msgs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned k;
    int unsigned n;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_vehicle_armed = 1'b0;
    in_offboard_active = 1'b0;
    out_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    tick_taken = 1'b0;
    send_gap = 0;
    send_steady = 0;
    stall_left = 0;
    free_left = 0;
    ticks_sent = 0;
    cycle_cnt = 0;
    errors = 0;
    mcfg = '{hover_ticks: 16'd100, takeoff_height_cm: 14'd300,
             mission_limit_ticks: 16'd450, arm_limit_ticks: 16'd120,
             prestream_count: 8'd20, arm_retry_ticks: 8'd10, land_retry_ticks: 8'd20};
    cur_phase = ahl_pkg::PHC_PRESTREAM;
    mission_age = 0;
    phase_age = 0;
    command_age = 0;
    streamed_cnt = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // upper bits set on purpose: the registers keep only their width
    cfg_write(ahl_pkg::REG_HOVER_TICKS, 32'hABCD_FFFF);
    cfg_write(ahl_pkg::REG_TAKEOFF_HT, 32'hFFFF_FFFF);
    cfg_write(ahl_pkg::REG_MISSION_LIMIT, 32'd65535);
    cfg_write(ahl_pkg::REG_ARM_LIMIT, 32'd65535);
    cfg_write(ahl_pkg::REG_PRESTREAM, 32'd255);
    cfg_write(ahl_pkg::REG_ARM_RETRY, 32'd0);
    cfg_write(ahl_pkg::REG_LAND_RETRY, 32'd255);

    // prestream with height above range; flags do not matter here
    push_tick(1'b0, 1'b0);
    push_tick(1'b1, 1'b1);
    push_tick(1'b1, 1'b0);
    wait_quiet();
    // zero prestream count requests at once
    cfg_write(ahl_pkg::REG_PRESTREAM, 32'd0);
    cfg_write(ahl_pkg::REG_TAKEOFF_HT, 32'd0);
    push_tick(1'b0, 1'b1);
    wait_quiet();
    // zero retry limit repeats mode and arm every tick
    push_tick(1'b0, 1'b1);
    push_tick(1'b1, 1'b0);
    wait_quiet();
    cfg_write(ahl_pkg::REG_ARM_RETRY, 32'd255);
    cfg_write(ahl_pkg::REG_TAKEOFF_HT, 32'd10000);
    push_tick(1'b0, 1'b0);
    wait_quiet();

    cfg_write(ahl_pkg::REG_ARM_RETRY, $urandom_range(1, 4));
    cfg_write(ahl_pkg::REG_TAKEOFF_HT, $urandom_range(1, 9999));
    cfg_write(ahl_pkg::REG_PRESTREAM, $urandom_range(1, 254));
    queue_ticks(30, MIX_NOT_BOTH);
    wait_quiet();

    // how the vehicle reaches landing is left to the seed
    k = $urandom_range(1, 4);
    case ($urandom_range(0, 2))
      0: begin
        push_tick(1'b1, 1'b1);
        queue_ticks(35, MIX_ANY);
        wait_quiet();
        if ($urandom_range(0, 1)) cfg_write(ahl_pkg::REG_HOVER_TICKS, 32'd0);
        else cfg_write(ahl_pkg::REG_HOVER_TICKS, phase_age + k);
        queue_ticks(6, MIX_ARMED);
      end
      1: begin
        queue_ticks(25, MIX_NOT_BOTH);
        wait_quiet();
        // retry and arm timeout fall on the same tick
        cfg_write(ahl_pkg::REG_ARM_RETRY, 32'd0);
        cfg_write(ahl_pkg::REG_ARM_LIMIT, phase_age + k - 1);
        queue_ticks(k, MIX_NOT_BOTH);
      end
      default: begin
        queue_ticks(15, MIX_ANY);
        wait_quiet();
        cfg_write(ahl_pkg::REG_MISSION_LIMIT, mission_age + k - 1);
        queue_ticks(k, MIX_ANY);
      end
    endcase
    wait_quiet();

    // landing: repeated land commands while still armed, then disarm
    cfg_write(ahl_pkg::REG_LAND_RETRY, 32'd0);
    queue_ticks(4, MIX_ARMED);
    wait_quiet();
    cfg_write(ahl_pkg::REG_LAND_RETRY, $urandom_range(1, 6));
    n = (ticks_sent < 124) ? 124 - ticks_sent : 4;
    queue_ticks(n, MIX_ARMED);
    push_tick(1'b0, 1'($urandom_range(0, 1)));
    wait_quiet();
    // mission over: further ticks are ignored
    queue_ticks(5, MIX_ANY);
    wait_quiet();

    if (errors == 0) begin
      $display("tb_arm_hover_land_mission_sequencer: clean");
    end else begin
      $display("tb_arm_hover_land_mission_sequencer: errors");
    end
    $finish;
  end

endmodule
